// ===== rtl/vna_pkg.sv =====
// Shared types, widths and helpers for the vertex normal accumulator.
// Used by vna_norm, vertex_normal_accumulator and tb_top; depends on nothing.
`default_nettype none
package vna_pkg;

	localparam int NUM_VERTICES_DEF = 65536;
	localparam int IDX_W   = 16;
	localparam int POS_W   = 24;
	localparam int DIFF_W  = 25;
	localparam int PROD_W  = 50;
	localparam int CROSS_W = 51;
	localparam int SUM_W   = 56;
	localparam int NRM_W   = 16;
	localparam int SCL_W   = 30;
	localparam int SQ_W    = 62;
	localparam int ROOT_W  = 64;
	localparam int REM_W   = 47;
	localparam int Q_W     = 16;

	localparam logic [Q_W-1:0] NRM_ONE = 16'd16384;

	typedef enum logic [1:0] {
		FN_LOAD  = 2'd0,
		FN_TRI   = 2'd1,
		FN_READ  = 2'd2,
		FN_CLEAR = 2'd3
	} func_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PRD_A,
		ST_PRD_B,
		ST_PRD_C,
		ST_PWAIT,
		ST_DIFF,
		ST_MUL,
		ST_SUB,
		ST_RMW_RD,
		ST_RMW_WR,
		ST_RD_SUM,
		ST_RD_WAIT,
		ST_NORM,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		N_IDLE,
		N_SCALE,
		N_SQ,
		N_SQRT,
		N_DINIT,
		N_DIV,
		N_DSTORE,
		N_DONE
	} norm_state_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] x;
		logic signed [SUM_W-1:0] y;
		logic signed [SUM_W-1:0] z;
	} sum_vec_t;

	typedef struct packed {
		logic signed [NRM_W-1:0] x;
		logic signed [NRM_W-1:0] y;
		logic signed [NRM_W-1:0] z;
	} nrm_vec_t;

	// Saturating add of a cross component into a normal sum.
	function automatic logic signed [SUM_W-1:0] sat_add(
		input logic signed [SUM_W-1:0]   s,
		input logic signed [CROSS_W-1:0] d
	);
		logic signed [SUM_W:0] t;
		t = (SUM_W+1)'(s) + (SUM_W+1)'(d);
		if (t[SUM_W] != t[SUM_W-1])
			return t[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return t[SUM_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== rtl/vna_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Holds vertex positions or normal sums; uses no package items.
`default_nettype none
module vna_ram #(
	parameter int W     = 8,
	parameter int DEPTH = 4,
	parameter int AW    = 2
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic          re,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

// ===== rtl/vna_norm.sv =====
// Iterative normalizer: scales a 56-bit sum vector, takes an integer square
// root and divides bit by bit to give Q1.14 components. Depends on vna_pkg.
`default_nettype none
module vna_norm import vna_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	input  wire sum_vec_t vec,
	output logic          done,
	output nrm_vec_t      nrm
);

	norm_state_t st_q, st_d;

	logic [SUM_W-1:0]  mag_q [3];
	logic [2:0]        neg_q;
	logic [SUM_W-1:0]  or_w;
	logic [1:0]        k_q;
	logic [SCL_W-1:0]  sel_w;
	logic [2*SCL_W-1:0] prod_q;
	logic [SQ_W-1:0]   acc_q;
	logic [ROOT_W-1:0] n_q, res_q, bit_q, try_w;
	logic [REM_W-1:0]  rem_q, dv_q;
	logic [Q_W-1:0]    q_q, cap_w;
	logic [3:0]        j_q;
	nrm_vec_t          nrm_q;

	assign or_w  = mag_q[0] | mag_q[1] | mag_q[2];
	assign try_w = res_q + bit_q;
	assign cap_w = (q_q > NRM_ONE) ? NRM_ONE : q_q;
	assign done  = (st_q == N_DONE);
	assign nrm   = nrm_q;

	always_comb begin
		case (k_q)
			2'd0:    sel_w = mag_q[0][SCL_W-1:0];
			2'd1:    sel_w = mag_q[1][SCL_W-1:0];
			default: sel_w = mag_q[2][SCL_W-1:0];
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= N_IDLE;
		else
			st_q <= st_d;
	end

	always_comb begin
		st_d = st_q;
		unique case (st_q)
			N_IDLE:   if (start) st_d = N_SCALE;
			N_SCALE: begin
				if (or_w == '0)
					st_d = N_DONE;
				else if (or_w[SUM_W-1:SCL_W] == '0 && or_w[SCL_W-1])
					st_d = N_SQ;
			end
			N_SQ:     if (k_q == 2'd3) st_d = N_SQRT;
			N_SQRT:   if (bit_q[0]) st_d = N_DINIT;
			N_DINIT:  st_d = N_DIV;
			N_DIV:    if (j_q == '0) st_d = N_DSTORE;
			N_DSTORE: st_d = (k_q == 2'd2) ? N_DONE : N_DINIT;
			N_DONE:   st_d = N_IDLE;
			default:  st_d = N_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			N_IDLE: begin
				if (start) begin
					mag_q[0] <= vec.x[SUM_W-1] ? SUM_W'(-vec.x) : SUM_W'(vec.x);
					mag_q[1] <= vec.y[SUM_W-1] ? SUM_W'(-vec.y) : SUM_W'(vec.y);
					mag_q[2] <= vec.z[SUM_W-1] ? SUM_W'(-vec.z) : SUM_W'(vec.z);
					neg_q    <= {vec.z[SUM_W-1], vec.y[SUM_W-1], vec.x[SUM_W-1]};
				end
			end
			N_SCALE: begin
				// One bit of shift a cycle until the largest magnitude sits at bit 29.
				if (or_w == '0) begin
					nrm_q <= '0;
				end else if (or_w[SUM_W-1:SCL_W] != '0) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] >> 1;
				end else if (!or_w[SCL_W-1]) begin
					for (int i = 0; i < 3; i++)
						mag_q[i] <= mag_q[i] << 1;
				end
				k_q    <= '0;
				prod_q <= '0;
				acc_q  <= '0;
			end
			N_SQ: begin
				prod_q <= sel_w * sel_w;
				acc_q  <= acc_q + SQ_W'(prod_q);
				k_q    <= k_q + 2'd1;
				if (k_q == 2'd3) begin
					n_q   <= ROOT_W'(acc_q + SQ_W'(prod_q));
					res_q <= '0;
					bit_q <= ROOT_W'(1) << 62;
				end
			end
			N_SQRT: begin
				if (n_q >= try_w) begin
					n_q   <= n_q - try_w;
					res_q <= (res_q >> 1) + bit_q;
				end else begin
					res_q <= res_q >> 1;
				end
				bit_q <= bit_q >> 2;
				k_q   <= '0;
			end
			N_DINIT: begin
				rem_q <= REM_W'({sel_w, 15'b0}) + REM_W'(res_q[30:0]);
				dv_q  <= {res_q[30:0], 16'b0};
				q_q   <= '0;
				j_q   <= 4'd15;
			end
			N_DIV: begin
				if (rem_q >= dv_q) begin
					rem_q <= rem_q - dv_q;
					q_q   <= {q_q[Q_W-2:0], 1'b1};
				end else begin
					q_q   <= {q_q[Q_W-2:0], 1'b0};
				end
				dv_q <= dv_q >> 1;
				j_q  <= j_q - 4'd1;
			end
			N_DSTORE: begin
				case (k_q)
					2'd0:    nrm_q.x <= neg_q[0] ? NRM_W'(-cap_w) : NRM_W'(cap_w);
					2'd1:    nrm_q.y <= neg_q[1] ? NRM_W'(-cap_w) : NRM_W'(cap_w);
					default: nrm_q.z <= neg_q[2] ? NRM_W'(-cap_w) : NRM_W'(cap_w);
				endcase
				k_q <= k_q + 2'd1;
			end
			default: ;
		endcase
	end

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> st_q == N_IDLE)
		else $error("normalizer started while busy");
	a_sq_from_scale: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == N_SQ && $past(st_q) != N_SQ) |-> $past(st_q) == N_SCALE)
		else $error("squaring entered without scaling");
	// The step counter wraps to 15 after the last of the sixteen steps.
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == N_DSTORE) |-> $past(st_q) == N_DIV && j_q == 4'd15)
		else $error("divider stored before sixteen steps");

endmodule
`default_nettype wire

// ===== rtl/vertex_normal_accumulator.sv =====
// Triangle: three position reads, cross product, three sum updates.
// Read: the one-bit scaling loop, the 32-step square root and three 16-step
// divisions, which a zero sum skips; a load is written as it is accepted.
// Clear: sweeps the sum memory, one entry a cycle.
// After reset the same sweep runs before the first item is taken.
// One item is processed at a time; the result waits in an output register.
`default_nettype none
module vertex_normal_accumulator import vna_pkg::*; #(
	parameter int NUM_VERTICES = NUM_VERTICES_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic [1:0]               func,
	input  wire logic [IDX_W-1:0]         first_index,
	input  wire logic [IDX_W-1:0]         second_index,
	input  wire logic [IDX_W-1:0]         third_index,
	input  wire logic signed [POS_W-1:0]  pos_x,
	input  wire logic signed [POS_W-1:0]  pos_y,
	input  wire logic signed [POS_W-1:0]  pos_z,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic [IDX_W-1:0]              vertex_out,
	output logic signed [NRM_W-1:0]       normal_x,
	output logic signed [NRM_W-1:0]       normal_y,
	output logic signed [NRM_W-1:0]       normal_z
);

	localparam int AW = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam logic [AW-1:0] LAST = AW'(NUM_VERTICES - 1);

	state_t state_q, state_d;

	logic          in_acc;
	logic          a_ok, b_ok, c_ok;
	logic [AW-1:0] a_q, b_q, c_q, clr_q, corner_w;
	logic [1:0]    corner_q;
	logic          a_ok_q;
	logic [IDX_W-1:0] vin_q;

	logic          pos_we, pos_re;
	logic [AW-1:0] pos_raddr;
	logic [3*POS_W-1:0] pos_rd, pa_q, pb_q, pc_q;

	logic          sum_we, sum_re;
	logic [AW-1:0] sum_addr;
	sum_vec_t      sum_rd, sum_wd;

	logic signed [DIFF_W-1:0]  ux_q, uy_q, uz_q, wx_q, wy_q, wz_q;
	logic signed [PROD_W-1:0]  p0_q, p1_q, p2_q, p3_q, p4_q, p5_q;
	logic signed [CROSS_W-1:0] cx_q, cy_q, cz_q;

	logic     norm_start, norm_done, out_load;
	sum_vec_t norm_vec;
	nrm_vec_t norm_res;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign a_ok     = int'(first_index) < NUM_VERTICES;
	assign b_ok     = int'(second_index) < NUM_VERTICES;
	assign c_ok     = int'(third_index) < NUM_VERTICES;

	assign pos_we = in_acc && func_t'(func) == FN_LOAD && a_ok;

	always_comb begin
		case (corner_q)
			2'd0:    corner_w = a_q;
			2'd1:    corner_w = b_q;
			default: corner_w = c_q;
		endcase
	end

	assign pos_re    = (state_q == ST_PRD_A || state_q == ST_PRD_B || state_q == ST_PRD_C);
	assign pos_raddr = (state_q == ST_PRD_A) ? a_q : (state_q == ST_PRD_B) ? b_q : c_q;

	vna_ram #(.W(3*POS_W), .DEPTH(NUM_VERTICES), .AW(AW)) u_pos (
		.clk   (clk),
		.we    (pos_we),
		.waddr (AW'(first_index)),
		.wdata ({pos_x, pos_y, pos_z}),
		.re    (pos_re),
		.raddr (pos_raddr),
		.rdata (pos_rd)
	);

	// Sum updates run strictly one corner after another: each write lands
	// before the next corner is read, so a repeated corner sees its own update.
	always_comb begin
		sum_we   = 1'b0;
		sum_re   = 1'b0;
		sum_addr = a_q;
		sum_wd   = '0;
		if (state_q == ST_CLEAR) begin
			sum_we   = 1'b1;
			sum_addr = clr_q;
		end else if (state_q == ST_RMW_RD) begin
			sum_re   = 1'b1;
			sum_addr = corner_w;
		end else if (state_q == ST_RMW_WR) begin
			sum_we   = 1'b1;
			sum_addr = corner_w;
			sum_wd.x = sat_add(sum_rd.x, cx_q);
			sum_wd.y = sat_add(sum_rd.y, cy_q);
			sum_wd.z = sat_add(sum_rd.z, cz_q);
		end else if (state_q == ST_RD_SUM) begin
			sum_re   = 1'b1;
		end
	end

	vna_ram #(.W(3*SUM_W), .DEPTH(NUM_VERTICES), .AW(AW)) u_sum (
		.clk   (clk),
		.we    (sum_we),
		.waddr (sum_addr),
		.wdata (sum_wd),
		.re    (sum_re),
		.raddr (sum_addr),
		.rdata (sum_rd)
	);

	assign norm_start = (state_q == ST_RD_WAIT);
	assign norm_vec   = a_ok_q ? sum_rd : '0;

	vna_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (norm_start),
		.vec    (norm_vec),
		.done   (norm_done),
		.nrm    (norm_res)
	);

	assign out_load = (state_q == ST_OUT) && (!out_valid || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_CLEAR;
		else
			state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:   if (clr_q == LAST) state_d = ST_IDLE;
			ST_IDLE: begin
				if (in_acc) begin
					unique case (func_t'(func))
						FN_TRI:   if (a_ok && b_ok && c_ok) state_d = ST_PRD_A;
						FN_READ:  state_d = ST_RD_SUM;
						FN_CLEAR: state_d = ST_CLEAR;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_PRD_A:   state_d = ST_PRD_B;
			ST_PRD_B:   state_d = ST_PRD_C;
			ST_PRD_C:   state_d = ST_PWAIT;
			ST_PWAIT:   state_d = ST_DIFF;
			ST_DIFF:    state_d = ST_MUL;
			ST_MUL:     state_d = ST_SUB;
			ST_SUB:     state_d = ST_RMW_RD;
			ST_RMW_RD:  state_d = ST_RMW_WR;
			ST_RMW_WR:  state_d = (corner_q == 2'd2) ? ST_IDLE : ST_RMW_RD;
			ST_RD_SUM:  state_d = ST_RD_WAIT;
			ST_RD_WAIT: state_d = ST_NORM;
			ST_NORM:    if (norm_done) state_d = ST_OUT;
			ST_OUT:     if (out_load) state_d = ST_IDLE;
			default:    state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == ST_CLEAR)
				clr_q <= clr_q + AW'(1);
			else if (in_acc && func_t'(func) == FN_CLEAR)
				clr_q <= '0;
			if (out_load)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q    <= AW'(first_index);
			b_q    <= AW'(second_index);
			c_q    <= AW'(third_index);
			a_ok_q <= a_ok;
			vin_q  <= first_index;
		end
		if (state_q == ST_PRD_B) pa_q <= pos_rd;
		if (state_q == ST_PRD_C) pb_q <= pos_rd;
		if (state_q == ST_PWAIT) pc_q <= pos_rd;
		if (state_q == ST_DIFF) begin
			ux_q <= DIFF_W'($signed(pb_q[3*POS_W-1:2*POS_W])) -
				DIFF_W'($signed(pa_q[3*POS_W-1:2*POS_W]));
			uy_q <= DIFF_W'($signed(pb_q[2*POS_W-1:POS_W])) -
				DIFF_W'($signed(pa_q[2*POS_W-1:POS_W]));
			uz_q <= DIFF_W'($signed(pb_q[POS_W-1:0])) - DIFF_W'($signed(pa_q[POS_W-1:0]));
			wx_q <= DIFF_W'($signed(pc_q[3*POS_W-1:2*POS_W])) -
				DIFF_W'($signed(pa_q[3*POS_W-1:2*POS_W]));
			wy_q <= DIFF_W'($signed(pc_q[2*POS_W-1:POS_W])) -
				DIFF_W'($signed(pa_q[2*POS_W-1:POS_W]));
			wz_q <= DIFF_W'($signed(pc_q[POS_W-1:0])) - DIFF_W'($signed(pa_q[POS_W-1:0]));
		end
		if (state_q == ST_MUL) begin
			p0_q <= PROD_W'(uy_q) * PROD_W'(wz_q);
			p1_q <= PROD_W'(uz_q) * PROD_W'(wy_q);
			p2_q <= PROD_W'(uz_q) * PROD_W'(wx_q);
			p3_q <= PROD_W'(ux_q) * PROD_W'(wz_q);
			p4_q <= PROD_W'(ux_q) * PROD_W'(wy_q);
			p5_q <= PROD_W'(uy_q) * PROD_W'(wx_q);
		end
		if (state_q == ST_SUB) begin
			cx_q     <= CROSS_W'(p0_q) - CROSS_W'(p1_q);
			cy_q     <= CROSS_W'(p2_q) - CROSS_W'(p3_q);
			cz_q     <= CROSS_W'(p4_q) - CROSS_W'(p5_q);
			corner_q <= 2'd0;
		end
		if (state_q == ST_RMW_WR)
			corner_q <= corner_q + 2'd1;
		if (out_load) begin
			vertex_out <= vin_q;
			normal_x   <= norm_res.x;
			normal_y   <= norm_res.y;
			normal_z   <= norm_res.z;
		end
	end

	a_done_in_norm: assert property (@(posedge clk) disable iff (!arst_n)
		norm_done |-> state_q == ST_NORM)
		else $error("normalizer finished outside a read");
	a_sum_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		sum_we |-> (state_q == ST_CLEAR || state_q == ST_RMW_WR))
		else $error("unexpected sum write");
	a_rmw_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RMW_WR |-> $past(state_q) == ST_RMW_RD)
		else $error("sum write without a preceding read");

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench for vertex_normal_accumulator: position loads, triangle accumulation,
// normalized reads and clears are checked against a behavioral predictor.
// Depends on vna_pkg and the vertex_normal_accumulator RTL only.
`default_nettype none
module tb_top;
	import vna_pkg::*;

	localparam int  VERTS      = 65536;
	localparam longint SUM_HI  = 64'sd36028797018963967;
	localparam longint SUM_LO  = -SUM_HI - 1;
	localparam longint CYCLE_LIMIT = 3000000;
	localparam int  POOL_SIZE  = 48;

	typedef struct {
		func_t                   fn;
		logic [IDX_W-1:0]        a, b, c;
		logic signed [POS_W-1:0] x, y, z;
	} mesh_op_t;

	typedef struct {
		logic [IDX_W-1:0] vtx;
		nrm_vec_t         n;
	} normal_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = FN_LOAD;
	logic [IDX_W-1:0] first_index = '0, second_index = '0, third_index = '0;
	logic signed [POS_W-1:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [IDX_W-1:0] vertex_out;
	logic signed [NRM_W-1:0] normal_x, normal_y, normal_z;

	// Predictor state.
	int     vpos_x [VERTS];
	int     vpos_y [VERTS];
	int     vpos_z [VERTS];
	longint acc_x [VERTS];
	longint acc_y [VERTS];
	longint acc_z [VERTS];
	normal_result_t pending_normals[$];

	int     idle_pct = 0;
	int     stall_pct = 0;
	int     hold_request = 0;
	int     hold_left = 0;
	int     errors = 0;
	longint cycles = 0;
	logic [IDX_W-1:0] pool[POOL_SIZE];

	vertex_normal_accumulator uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.func(func), .first_index(first_index), .second_index(second_index),
		.third_index(third_index), .pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z),
		.out_valid(out_valid), .out_ready(out_ready), .vertex_out(vertex_out),
		.normal_x(normal_x), .normal_y(normal_y), .normal_z(normal_z)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver: random stalls, plus a long hold-off when one is requested.
	always @(negedge clk) begin
		if (hold_request > 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready = 1'b0;
		end else begin
			out_ready = ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 40)
			$display("mismatch at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
	endtask

	function automatic longint sat_sum(input longint s, input longint d);
		longint t;
		t = s + d;
		if (t > SUM_HI) return SUM_HI;
		if (t < SUM_LO) return SUM_LO;
		return t;
	endfunction

	function automatic nrm_vec_t unit_normal(input longint vx, input longint vy, input longint vz);
		longint vals[3];
		longint unsigned mag[3];
		longint unsigned m, sq, root, bitv, rem, q;
		int msb;
		logic signed [NRM_W-1:0] outv[3];
		nrm_vec_t res;
		vals[0] = vx; vals[1] = vy; vals[2] = vz;
		m = 0;
		for (int i = 0; i < 3; i++) begin
			mag[i] = (vals[i] < 0) ? -vals[i] : vals[i];
			if (mag[i] > m) m = mag[i];
		end
		if (m == 0) begin
			res.x = '0; res.y = '0; res.z = '0;
			return res;
		end
		msb = 0;
		while (msb < 63 && (m >> (msb + 1)) != 0) msb++;
		sq = 0;
		for (int i = 0; i < 3; i++) begin
			if (msb < 29) mag[i] = mag[i] << (29 - msb);
			else mag[i] = mag[i] >> (msb - 29);
			sq += mag[i] * mag[i];
		end
		// Integer square root, two bits of the radicand per step.
		rem = sq;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > rem) bitv >>= 2;
		while (bitv != 0) begin
			if (rem >= root + bitv) begin
				rem -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		for (int i = 0; i < 3; i++) begin
			q = (mag[i] * 32768 + root) / (2 * root);
			if (q > 16384) q = 16384;
			outv[i] = (vals[i] < 0) ? -q[NRM_W-1:0] : q[NRM_W-1:0];
		end
		res.x = outv[0]; res.y = outv[1]; res.z = outv[2];
		return res;
	endfunction

	task automatic apply_op(input mesh_op_t op);
		longint ux, uy, uz, wx, wy, wz, cx, cy, cz;
		normal_result_t r;
		int idx[3];
		case (op.fn)
			FN_LOAD: begin
				vpos_x[op.a] = op.x;
				vpos_y[op.a] = op.y;
				vpos_z[op.a] = op.z;
			end
			FN_TRI: begin
				ux = vpos_x[op.b] - vpos_x[op.a];
				uy = vpos_y[op.b] - vpos_y[op.a];
				uz = vpos_z[op.b] - vpos_z[op.a];
				wx = vpos_x[op.c] - vpos_x[op.a];
				wy = vpos_y[op.c] - vpos_y[op.a];
				wz = vpos_z[op.c] - vpos_z[op.a];
				cx = uy * wz - uz * wy;
				cy = uz * wx - ux * wz;
				cz = ux * wy - uy * wx;
				idx[0] = op.a; idx[1] = op.b; idx[2] = op.c;
				foreach (idx[i]) begin
					acc_x[idx[i]] = sat_sum(acc_x[idx[i]], cx);
					acc_y[idx[i]] = sat_sum(acc_y[idx[i]], cy);
					acc_z[idx[i]] = sat_sum(acc_z[idx[i]], cz);
				end
			end
			FN_READ: begin
				r.vtx = op.a;
				r.n = unit_normal(acc_x[op.a], acc_y[op.a], acc_z[op.a]);
				pending_normals.push_back(r);
			end
			default: begin
				for (int i = 0; i < VERTS; i++) begin
					acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
				end
			end
		endcase
	endtask

	// Drives one item from a falling edge and holds it until it is accepted.
	task automatic send_op(input mesh_op_t op);
		while ($urandom_range(99) < idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		func = op.fn;
		first_index = op.a;
		second_index = op.b;
		third_index = op.c;
		pos_x = op.x;
		pos_y = op.y;
		pos_z = op.z;
		in_valid = 1'b1;
		do @(posedge clk); while (!in_ready);
		apply_op(op);
		@(negedge clk);
	endtask

	function automatic mesh_op_t make_op(input func_t fn, input int a, input int b,
			input int c);
		mesh_op_t op;
		op.fn = fn;
		op.a = IDX_W'(a);
		op.b = IDX_W'(b);
		op.c = IDX_W'(c);
		op.x = POS_W'($urandom);
		op.y = POS_W'($urandom);
		op.z = POS_W'($urandom);
		return op;
	endfunction

	task automatic load_vertex(input int v, input int x, input int y, input int z);
		mesh_op_t op;
		op = make_op(FN_LOAD, v, $urandom, $urandom);
		op.x = POS_W'(x); op.y = POS_W'(y); op.z = POS_W'(z);
		send_op(op);
	endtask

	task automatic wait_drained();
		in_valid = 1'b0;
		while (pending_normals.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	always @(posedge clk) begin
		normal_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_normals.size() == 0) begin
				report_mismatch("unexpected result, vertex", vertex_out, -1);
			end else begin
				want = pending_normals.pop_front();
				if (vertex_out !== want.vtx) report_mismatch("vertex_out", vertex_out, want.vtx);
				if (normal_x !== want.n.x) report_mismatch("normal_x", normal_x, want.n.x);
				if (normal_y !== want.n.y) report_mismatch("normal_y", normal_y, want.n.y);
				if (normal_z !== want.n.z) report_mismatch("normal_z", normal_z, want.n.z);
			end
		end
	end

	// Extreme positions, every function, zero sums, repeated corners and clear.
	task automatic test_directed();
		load_vertex(0, -8388608, -8388608, -8388608);
		load_vertex(65535, 8388607, 8388607, 8388607);
		load_vertex(1, 8388607, -8388608, 0);
		load_vertex(2, 256, 0, 0);
		load_vertex(3, 0, 256, 0);
		send_op(make_op(FN_READ, 0, $urandom, $urandom));
		send_op(make_op(FN_READ, 12345, $urandom, $urandom));
		send_op(make_op(FN_TRI, 0, 65535, 1));
		send_op(make_op(FN_TRI, 0, 2, 3));
		send_op(make_op(FN_TRI, 2, 2, 3));
		send_op(make_op(FN_TRI, 3, 2, 3));
		send_op(make_op(FN_TRI, 1, 1, 1));
		send_op(make_op(FN_READ, 0, $urandom, $urandom));
		send_op(make_op(FN_READ, 1, $urandom, $urandom));
		send_op(make_op(FN_READ, 2, $urandom, $urandom));
		send_op(make_op(FN_READ, 3, $urandom, $urandom));
		send_op(make_op(FN_READ, 65535, $urandom, $urandom));
		send_op(make_op(FN_CLEAR, $urandom, $urandom, $urandom));
		send_op(make_op(FN_READ, 0, $urandom, $urandom));
		send_op(make_op(FN_READ, 3, $urandom, $urandom));
	endtask

	// Two large triangles repeated many times drive a sum into its upper saturation limit.
	task automatic test_saturation();
		load_vertex(10, 0, -8388608, -8388608);
		load_vertex(11, 0, 8388607, -8388608);
		load_vertex(12, 0, -8388608, 8388607);
		load_vertex(13, 8388607, 0, -8388608);
		for (int i = 0; i < 140; i++) begin
			send_op(make_op(FN_TRI, 10, 11, 12));
			send_op(make_op(FN_TRI, 10, 12, 13));
		end
		for (int v = 10; v < 14; v++)
			send_op(make_op(FN_READ, v, $urandom, $urandom));
		send_op(make_op(FN_CLEAR, $urandom, $urandom, $urandom));
	endtask

	// Reads pile up while the receiver holds off, so the block stalls its input.
	task automatic test_backpressure();
		hold_request = 600;
		for (int i = 0; i < 8; i++)
			send_op(make_op(FN_READ, pool[$urandom_range(POOL_SIZE-1)], $urandom, $urandom));
		wait_drained();
	endtask

	task automatic random_phase(input int n_items);
		mesh_op_t op;
		int pick;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(999);
			if (pick < 120) begin
				op = make_op(FN_LOAD, pool[$urandom_range(POOL_SIZE-1)], $urandom, $urandom);
				if ($urandom_range(1)) begin
					op.x = $signed(op.x) >>> 10;
					op.y = $signed(op.y) >>> 10;
					op.z = $signed(op.z) >>> 10;
				end
			end else if (pick < 600) begin
				op = make_op(FN_TRI, pool[$urandom_range(POOL_SIZE-1)],
					pool[$urandom_range(POOL_SIZE-1)], pool[$urandom_range(POOL_SIZE-1)]);
				if ($urandom_range(9) == 0) op.c = op.a;
			end else if (pick < 997) begin
				op = make_op(FN_READ, pool[$urandom_range(POOL_SIZE-1)], $urandom, $urandom);
				if ($urandom_range(4) == 0) op.a = IDX_W'($urandom);
			end else begin
				op = make_op(FN_CLEAR, $urandom, $urandom, $urandom);
			end
			send_op(op);
		end
	endtask

	task automatic test_random();
		pool[0] = 16'd0;
		pool[1] = 16'hFFFF;
		for (int i = 2; i < POOL_SIZE; i++) pool[i] = IDX_W'($urandom);
		for (int i = 0; i < POOL_SIZE; i++)
			load_vertex(pool[i], $urandom, $urandom, $urandom);
		random_phase(250);
		idle_pct = 66; stall_pct = 0;
		random_phase(250);
		idle_pct = 0; stall_pct = 66;
		random_phase(250);
		idle_pct = 16; stall_pct = 16;
		random_phase(250);
		idle_pct = 0; stall_pct = 0;
		wait_drained();
	endtask

	initial begin
		for (int i = 0; i < VERTS; i++) begin
			acc_x[i] = 0; acc_y[i] = 0; acc_z[i] = 0;
		end
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_saturation();
		test_random();
		test_backpressure();
		in_valid = 1'b0;
		while (pending_normals.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
		if (errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire

// ===== vertex_normal_accumulator.f =====
rtl/vna_pkg.sv
rtl/vna_ram.sv
rtl/vna_norm.sv
rtl/vertex_normal_accumulator.sv
verif/tb_top.sv
